### rtl/core/bdq_pkg.sv
// shared types and constants for the bounded deque with middle insert/remove
// no dependencies
package bdq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INS_MID    = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REM_MID    = 3'd5
  } bdq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } bdq_status_e;

  // shift command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
  } bdq_cmd_t;

endpackage

### rtl/core/bdq_cell.sv
// one storage cell of the deque chain: holds, loads, or takes a neighbor's value
// depends on bdq_pkg
module bdq_cell import bdq_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IDX_W-1:0]  cell_idx_i,
  input  bdq_cmd_t          cmd_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (cell_idx_i == cmd_i.pos) begin
        data_d = value_i;
      end else if (cell_idx_i > cmd_i.pos) begin
        data_d = left_i;
      end
    end else if (cmd_i.rem && (cell_idx_i >= cmd_i.pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### rtl/core/bdq_ctrl.sv
// entry counter and operation decode: picks the shift position and status
// depends on bdq_pkg
module bdq_ctrl import bdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [2:0]       op_i,
  output bdq_cmd_t         cmd_o,
  output bdq_status_e      status_o,
  output logic [CNT_W-1:0] count_o,
  output logic [CNT_W-1:0] count_next_o
);

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic [CNT_W-1:0] n_m1;
  logic [IDX_W-1:0] mid;
  logic             full;
  logic             empty;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);
  assign n_m1  = count_q - CNT_W'(1);
  assign mid   = IDX_W'(n_m1 >> 1);

  always_comb begin
    cmd_o    = '0;
    status_o = ST_OK;
    count_d  = count_q;
    case (bdq_op_e'(op_i))
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INS_MID: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd_o.ins = 1'b1;
          count_d   = count_q + CNT_W'(1);
          case (bdq_op_e'(op_i))
            OP_PUSH_FRONT: cmd_o.pos = '0;
            OP_PUSH_BACK:  cmd_o.pos = IDX_W'(count_q);
            default:       cmd_o.pos = empty ? '0 : mid + IDX_W'(1);
          endcase
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_REM_MID: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          cmd_o.rem = 1'b1;
          count_d   = n_m1;
          case (bdq_op_e'(op_i))
            OP_POP_FRONT: cmd_o.pos = '0;
            OP_POP_BACK:  cmd_o.pos = IDX_W'(n_m1);
            default:      cmd_o.pos = mid;
          endcase
        end
      end
      default: begin
        // unused codes leave everything as it is
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

### rtl/core/bounded_deque_middle_ops.sv
// top level of the bounded deque with push/pop at both ends and at the middle
// depends on bdq_pkg, bdq_ctrl and bdq_cell
//
//  channel  | dir | tdata (low bit up)                 | tuser (low bit up)
//  s_axis   | in  | value[31:0], zero pad to 32        | operation[2:0]
//  m_axis   | out | removed_value[31:0], occupancy[36:32], zero pad to 40 | status[1:0]
//
// one operation per clock while the result register can take it: all cells take their next value in the same cycle
// from a compare of their own index against the shift position
// the result is registered, so it shows in the cycle after the input transfer
// s_axis_tready stays high while the result register is free or being drained
// reset clears the entry count and the result valid; cell contents are not reset
module bounded_deque_middle_ops import bdq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input operations
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic [2:0]  s_axis_tuser,   // operation[2:0]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // removed_value[31:0], occupancy[36:32], zeros
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  logic              s_fire;
  bdq_cmd_t          cmd;
  bdq_status_e       status;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] removed;

  // result register
  logic              out_valid_q;
  logic [DATA_W-1:0] removed_q;
  logic [1:0]        status_q;
  logic [OCC_W-1:0]  occ_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  bdq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (s_fire),
    .op_i         (s_axis_tuser),
    .cmd_o        (cmd),
    .status_o     (status),
    .count_o      (count),
    .count_next_o (count_next)
  );

  // the chain: each cell sees its left and right neighbor; an end cell sees itself on its open side
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    bdq_cell u_cell (
      .clk_i      (clk_i),
      .en_i       (s_fire),
      .cell_idx_i (IDX_W'(i)),
      .cmd_i      (cmd),
      .value_i    (s_axis_tdata),
      .left_i     (left),
      .right_i    (right),
      .data_o     (cell_data[i])
    );
  end

  // value leaving the chain: the entry at the shift position on a removal, all ones on an empty removal, else zero
  always_comb begin
    if (cmd.rem) begin
      removed = cell_data[cmd.pos];
    end else if (status == ST_EMPTY) begin
      removed = '1;
    end else begin
      removed = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      removed_q <= removed;
      status_q  <= status;
      occ_q     <= OCC_W'(count_next);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, occ_q, removed_q};
  assign m_axis_tuser  = status_q;

  // full status only ever reports a full deque
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (occ_q == OCC_W'(CAPACITY)))
    else $error("full status with occupancy below capacity");

  // empty removal reports -1 and nothing stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> (removed_q == '1) && (occ_q == '0))
    else $error("empty removal with wrong value or occupancy");

  // an accepted insert that is not full grows the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && cmd.ins |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the entry count");

  // the count never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

endmodule

### test/tb.sv
// self-checking testbench for bounded_deque_middle_ops: random and directed deque operations
// with a queue-based predictor and scoreboard; depends on bdq_pkg and the rtl top level
module tb import bdq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // the two spare codes of the 3-bit operation field, which must leave the deque alone
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 5;

  typedef struct {
    logic [31:0] removed;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } deque_result_t;

  // biases for the random runs: fill toward full, drain toward empty, or mix
  typedef enum int {FILL_RUN, DRAIN_RUN, MIXED_RUN} run_kind_e;

  // predicts each operation on its own copy of the deque and checks results in order
  class deque_scoreboard;
    logic [31:0]   contents[$];
    deque_result_t expected_q[$];
    int errors;
    int checked;
    int full_hits;
    int empty_hits;
    int peak;

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted operation: update the deque copy and queue its result
    function void note_operation(logic [2:0] op, logic [31:0] value);
      deque_result_t res;
      int n;
      int pos;
      n = contents.size();
      res.removed = '0;
      res.status = ST_OK;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INS_MID: begin
          if (n >= int'(CAPACITY)) begin
            res.status = ST_FULL;
            full_hits++;
          end else begin
            if (op == OP_PUSH_FRONT) pos = 0;
            else if (op == OP_PUSH_BACK) pos = n;
            else pos = (n == 0) ? 0 : (n - 1) / 2 + 1;
            contents.insert(pos, value);
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_REM_MID: begin
          if (n == 0) begin
            res.status = ST_EMPTY;
            res.removed = '1;
            empty_hits++;
          end else begin
            if (op == OP_POP_FRONT) pos = 0;
            else if (op == OP_POP_BACK) pos = n - 1;
            else pos = (n - 1) / 2;
            res.removed = contents[pos];
            contents.delete(pos);
          end
        end
        default: ;  // spare codes change nothing
      endcase
      res.occupancy = 5'(contents.size());
      if (contents.size() > peak) peak = contents.size();
      expected_q.push_back(res);
    endfunction

    task check_result(logic [31:0] removed, logic [1:0] status, logic [4:0] occupancy);
      deque_result_t exp_res;
      if (expected_q.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding");
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (removed !== exp_res.removed)
        report_mismatch($sformatf("removed_value %h, predicted %h", removed, exp_res.removed));
      if (status !== exp_res.status)
        report_mismatch($sformatf("status %0d, predicted %0d", status, exp_res.status));
      if (occupancy !== exp_res.occupancy)
        report_mismatch($sformatf("occupancy %0d, predicted %0d", occupancy,
                                  exp_res.occupancy));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // value[31:0]
  logic [2:0]  s_axis_tuser = '0;    // operation[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // removed_value[31:0], occupancy[36:32], zeros
  logic [1:0]  m_axis_tuser;         // status[1:0]

  deque_scoreboard sb = new();

  int tx_idle_pct;        // chance per cycle that the operation side holds back
  int rx_idle_pct;        // chance per cycle that the result side is not ready
  bit stall_req = 1'b0;   // asks the result side for one long hold-off
  int stall_len;
  int ops_sent;
  int cycle_count;

  bounded_deque_middle_ops uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random back-pressure, or a long hold-off counted here when asked
  always @(negedge clk_i) begin
    if (stall_req) begin
      stall_req = 1'b0;
      m_axis_tready <= 1'b0;
      repeat (stall_len - 1) @(negedge clk_i);
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result monitor, sampled at the rising edge before the block updates
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tdata[39:37] !== 3'b000)
        sb.report_mismatch($sformatf("tdata pad bits %b", m_axis_tdata[39:37]));
      sb.check_result(m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[36:32]);
    end
  end

  // offer one operation and hold it until the transfer; tvalid stays high afterward
  task send_op(logic [2:0] op, logic [31:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_operation(op, value);
    ops_sent++;
  endtask

  // drop the offer and wait for every predicted result to come back
  task wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // values lean on the extremes, all-ones and small values, the rest is full random
  function logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4: return 32'($urandom_range(255));
      default: return $urandom();
    endcase
  endfunction

  function logic [2:0] pick_op(run_kind_e kind);
    int roll;
    int insert_pct;
    roll = $urandom_range(99);
    if (roll < 3) return ($urandom_range(1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
    case (kind)
      FILL_RUN:  insert_pct = 78;
      DRAIN_RUN: insert_pct = 22;
      default:   insert_pct = 50;
    endcase
    if ($urandom_range(99) < insert_pct)
      return 3'($urandom_range(OP_INS_MID, OP_PUSH_FRONT));
    return 3'($urandom_range(OP_REM_MID, OP_POP_FRONT));
  endfunction

  // runs of fill or drain bias so the deque swings between empty and full
  task run_random(int count);
    run_kind_e kind;
    int run_len;
    int done_cnt;
    done_cnt = 0;
    while (done_cnt < count) begin
      kind = run_kind_e'($urandom_range(2));
      run_len = $urandom_range(8, 40);
      for (int i = 0; i < run_len && done_cnt < count; i++) begin
        send_op(pick_op(kind), pick_value());
        done_cnt++;
      end
    end
  endtask

  initial begin
    tx_idle_pct = 36;
    rx_idle_pct = 66;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // removals on an empty deque, spare codes, then the one-entry middle cases
    send_op(OP_POP_FRONT, $urandom());
    send_op(OP_POP_BACK, $urandom());
    send_op(OP_REM_MID, $urandom());
    send_op(OP_SPARE_6, 32'haaaa_aaaa);
    send_op(OP_SPARE_7, 32'h5555_5555);
    send_op(OP_INS_MID, 32'h8000_0000);    // empty deque: lands at the front
    send_op(OP_REM_MID, $urandom());       // single entry: takes position zero
    send_op(OP_PUSH_BACK, 32'h7fff_ffff);
    send_op(OP_INS_MID, 32'hffff_ffff);    // single entry: appends behind it
    send_op(OP_PUSH_FRONT, 32'h0000_0000);
    send_op(OP_INS_MID, 32'h5555_5555);
    send_op(OP_PUSH_BACK, 32'haaaa_aaaa);
    send_op(OP_REM_MID, $urandom());
    send_op(OP_POP_FRONT, $urandom());
    send_op(OP_POP_BACK, $urandom());
    send_op(OP_SPARE_6, $urandom());
    send_op(OP_REM_MID, $urandom());
    send_op(OP_POP_BACK, $urandom());
    send_op(OP_POP_BACK, $urandom());
    wait_results_drained();

    // first mix: sender idles lightly, receiver heavily
    run_random(200);
    // long hold-off on the result side while operations keep coming
    stall_len = 80;
    stall_req = 1'b1;
    tx_idle_pct = 0;
    run_random(40);
    tx_idle_pct = 36;
    run_random(200);
    wait_results_drained();

    // second mix: roles swapped
    tx_idle_pct = 66;
    rx_idle_pct = 36;
    run_random(440);
    wait_results_drained();

    // back to back, no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(450);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d operations, %0d results checked, %0d full rejections, %0d empty removals",
             ops_sent, sb.checked, sb.full_hits, sb.empty_hits);
    $display("peak occupancy %0d, three back-pressure mixes plus one long result stall", sb.peak);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### bounded_deque_middle_ops.f
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bdq_ctrl.sv
rtl/core/bounded_deque_middle_ops.sv
test/tb.sv
